// File: sv/fsc_pkg.sv
// Shared package of the frustum sphere culling block: word format, operation
// codes, the fixed-point rounding and saturation helpers and the plane rules.
// Depends on nothing.
package fsc_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
  localparam int ACC_BITS  = WORD_BITS + 3;
  localparam int REM_BITS  = WORD_BITS + 4;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0] acc_t;

  localparam logic [1:0] OP_LOAD_VIEW = 2'd0;
  localparam logic [1:0] OP_LOAD_PROJ = 2'd1;
  localparam logic [1:0] OP_TEST      = 2'd2;

  // Control from the sequencer to the shared divide / square root unit.
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_ctl_t;

  localparam acc_t ACC_MAX = acc_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam acc_t ACC_MIN = -ACC_MAX - acc_t'(1);

  // Rounds a product magnitude to nearest (ties away from zero), saturates it
  // and applies the sign.
  function automatic word_t fx_round(prod_t p, logic neg);
    logic [PROD_BITS:0] s;
    logic [PROD_BITS:0] lim;
    s = ({1'b0, p} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? ((PROD_BITS+1)'(1) << (WORD_BITS - 1))
              : (((PROD_BITS+1)'(1) << (WORD_BITS - 1)) - (PROD_BITS+1)'(1));
    if (s > lim) s = lim;
    return neg ? word_t'(~s[WORD_BITS-1:0] + 1'b1) : word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_acc(acc_t v);
    word_t r;
    if (v > ACC_MAX) r = ACC_MAX[WORD_BITS-1:0];
    else if (v < ACC_MIN) r = ACC_MIN[WORD_BITS-1:0];
    else r = v[WORD_BITS-1:0];
    return r;
  endfunction

  // Plane order: right, left, bottom, top, back, front.
  function automatic logic [1:0] plane_col(logic [2:0] p);
    return p[2:1];
  endfunction

  function automatic logic plane_add(logic [2:0] p);
    logic r;
    unique case (p)
      3'd1, 3'd2, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/fsc_mul.sv
// Shared multiplier of the frustum culling block: magnitude product of two
// signed words with the product sign, registered. Depends on fsc_pkg.
module fsc_mul import fsc_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t a_i,
  input  word_t b_i,
  output prod_t prod_o,
  output logic  neg_o
);

  logic [WORD_BITS-1:0] a_mag, b_mag;
  prod_t prod_d, prod_q;
  logic  neg_q;

  assign a_mag  = a_i[WORD_BITS-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag  = b_i[WORD_BITS-1] ? (~b_i + 1'b1) : b_i;
  assign prod_d = prod_t'(a_mag) * prod_t'(b_mag);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg_q  <= a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
    end
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

// File: sv/fsc_divsqrt.sv
// Shared iterative unit of the frustum culling block: restoring division
// (one quotient bit a cycle) or integer square root (one root bit a cycle).
// Depends on fsc_pkg.
module fsc_divsqrt import fsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ds_ctl_t              ctl_i,
  input  prod_t                num_i,
  input  logic [WORD_BITS-1:0] den_i,
  output logic                 done_o,
  output logic [QUOT_BITS-1:0] res_o
);

  logic                 run_q, sqrt_q, done_q;
  logic [5:0]           cnt_q;
  prod_t                sh_q;
  logic [REM_BITS-1:0]  rem_q, r2, trial, rem_d;
  logic [QUOT_BITS-1:0] res_q, res_d;
  logic                 take;

  always_comb begin
    if (sqrt_q) begin
      r2    = {rem_q[REM_BITS-3:0], sh_q[PROD_BITS-1 -: 2]};
      trial = {2'b00, res_q[WORD_BITS-1:0], 2'b01};
    end else begin
      r2    = {rem_q[REM_BITS-2:0], sh_q[PROD_BITS-1]};
      trial = REM_BITS'(den_i);
    end
    take  = (r2 >= trial);
    rem_d = take ? (r2 - trial) : r2;
    res_d = {res_q[QUOT_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= ctl_i.is_sqrt ? 6'(WORD_BITS - 1) : 6'(QUOT_BITS - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sqrt_q <= ctl_i.is_sqrt;
      sh_q   <= num_i;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (run_q) begin
      sh_q  <= sqrt_q ? (sh_q << 2) : (sh_q << 1);
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: sv/frustum_sphere_cull.sv
// Top level of the frustum sphere culling block: matrix storage, plane store
// and the sequencer driving the shared multiplier and divide/sqrt unit.
// Depends on fsc_pkg, fsc_mul and fsc_divsqrt.
//
//  channel   handshake         payload
//  command   start / busy      operation_i, row_index_i, elem_*_i, center_*_i, radius_i
//  result    done_o (1 cycle)  inside_res_o
//
// Loads keep busy low. A sphere test with current planes keeps busy high
// while 18 products go through the single multiplier, then through a drain
// state and the result state; no new command is taken until busy falls.
// After a load, the next test first rebuilds the planes: the matrix
// product, then per plane the extraction, a sum of squares, a
// 32-step square root and four 48-step divisions (skipped when the normal
// has zero length), and only then the sphere test itself.
// Reset sets both matrices to identity and marks the planes stale. The
// receiver cannot stall; a result is shown on the single done_o cycle.
module frustum_sphere_cull import fsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [1:0]           row_index_i,
  input  word_t                elem_0_i,
  input  word_t                elem_1_i,
  input  word_t                elem_2_i,
  input  word_t                elem_3_i,
  input  word_t                center_x_i,
  input  word_t                center_y_i,
  input  word_t                center_z_i,
  input  logic [WORD_BITS-2:0] radius_i,
  output logic                 done_o,
  output logic                 inside_res_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MMUL   = 4'd1;
  localparam logic [3:0] S_MDRAIN = 4'd2;
  localparam logic [3:0] S_PADD   = 4'd3;
  localparam logic [3:0] S_PSQ    = 4'd4;
  localparam logic [3:0] S_PSQD   = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_SQRTW  = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DIVW   = 4'd9;
  localparam logic [3:0] S_TEST   = 4'd10;
  localparam logic [3:0] S_TDRAIN = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam logic [1:0] KIND_MAT = 2'd0;
  localparam logic [1:0] KIND_SQ  = 2'd1;
  localparam logic [1:0] KIND_TST = 2'd2;

  localparam word_t ONE = word_t'(1) << FRAC_BITS;

  logic [3:0]  state_q;
  logic [5:0]  cnt_q;
  logic [2:0]  p_q;
  logic        stale_q, outside_q;
  word_t       view_q [16];
  word_t       proj_q [16];
  word_t       c_q    [16];
  word_t       pl_q   [24];
  word_t       cx_q, cy_q, cz_q;
  logic [WORD_BITS-2:0] r_q;
  logic [WORD_BITS-1:0] len_q;

  // Multiplier pipeline tags.
  logic        pv_q, last_q;
  logic [1:0]  kind_q;
  logic [3:0]  tag_q;
  acc_t        acc_q;
  prod_t       ss_q;

  logic        issue, last_d;
  logic [1:0]  kind_d;
  logic [3:0]  tag_d;
  word_t       mul_a, mul_b;
  prod_t       prod;
  logic        prod_neg;
  ds_ctl_t     ds_ctl;
  prod_t       ds_num;
  logic        ds_done;
  logic [QUOT_BITS-1:0] ds_res;

  logic [4:0]  pl_idx;
  word_t       pl_cur;
  logic [WORD_BITS-1:0] pl_mag;
  logic        accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign pl_idx = {p_q, cnt_q[1:0]};
  assign pl_cur = pl_q[pl_idx];
  assign pl_mag = pl_cur[WORD_BITS-1] ? (~pl_cur + 1'b1) : pl_cur;

  always_comb begin
    issue  = 1'b0;
    last_d = 1'b0;
    kind_d = KIND_MAT;
    tag_d  = '0;
    mul_a  = view_q[{cnt_q[5:4], cnt_q[1:0]}];
    mul_b  = proj_q[{cnt_q[1:0], cnt_q[3:2]}];
    ds_ctl = '0;
    ds_num = {pl_mag, {WORD_BITS{1'b0}}};
    unique case (state_q)
      S_MMUL: begin
        issue  = 1'b1;
        last_d = (cnt_q[1:0] == 2'd3);
        tag_d  = cnt_q[5:2];
      end
      S_PSQ: begin
        issue  = 1'b1;
        kind_d = KIND_SQ;
        mul_a  = pl_cur;
        mul_b  = pl_cur;
      end
      S_TEST: begin
        issue  = 1'b1;
        kind_d = KIND_TST;
        last_d = (cnt_q[1:0] == 2'd2);
        tag_d  = {1'b0, p_q};
        mul_a  = pl_cur;
        unique case (cnt_q[1:0])
          2'd0:    mul_b = cx_q;
          2'd1:    mul_b = cy_q;
          default: mul_b = cz_q;
        endcase
      end
      S_SQRT: begin
        ds_ctl.start   = 1'b1;
        ds_ctl.is_sqrt = 1'b1;
        ds_num         = ss_q;
      end
      S_DIV: begin
        ds_ctl.start = 1'b1;
      end
      default: ;
    endcase
  end

  fsc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (issue),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .neg_o  (prod_neg)
  );

  fsc_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ds_ctl),
    .num_i  (ds_num),
    .den_i  (len_q),
    .done_o (ds_done),
    .res_o  (ds_res)
  );

  // Accumulation of the registered product.
  word_t fx;
  acc_t  sum, dist_sum;
  word_t dist_w;
  logic signed [WORD_BITS:0] neg_r;
  assign fx       = fx_round(prod, prod_neg);
  assign sum      = acc_q + acc_t'(fx);
  assign dist_sum = sum + acc_t'(pl_q[{tag_q[2:0], 2'd3}]);
  assign dist_w   = sat_acc(dist_sum);
  assign neg_r    = -$signed({2'b00, r_q});

  // Division write-back with saturation.
  logic                 div_neg;
  logic [QUOT_BITS-1:0] q_lim, q_sat;
  word_t                q_val;
  assign div_neg = pl_cur[WORD_BITS-1];
  assign q_lim   = div_neg ? (QUOT_BITS'(1) << (WORD_BITS - 1))
                           : ((QUOT_BITS'(1) << (WORD_BITS - 1)) - QUOT_BITS'(1));
  assign q_sat   = (ds_res > q_lim) ? q_lim : ds_res;
  assign q_val   = div_neg ? word_t'(~q_sat[WORD_BITS-1:0] + 1'b1)
                           : word_t'(q_sat[WORD_BITS-1:0]);

  // Plane extraction for the current plane, all four rows at once.
  word_t pl_new [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pl_new[i] = sat_acc(plane_add(p_q)
          ? acc_t'(c_q[i*4+3]) + acc_t'(c_q[{i[1:0], plane_col(p_q)}])
          : acc_t'(c_q[i*4+3]) - acc_t'(c_q[{i[1:0], plane_col(p_q)}]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      p_q       <= '0;
      stale_q   <= 1'b1;
      outside_q <= 1'b0;
      pv_q      <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        view_q[i] <= (i % 5 == 0) ? ONE : '0;
        proj_q[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else begin
      pv_q <= issue;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (operation_i == OP_LOAD_VIEW) begin
              view_q[{row_index_i, 2'd0}] <= elem_0_i;
              view_q[{row_index_i, 2'd1}] <= elem_1_i;
              view_q[{row_index_i, 2'd2}] <= elem_2_i;
              view_q[{row_index_i, 2'd3}] <= elem_3_i;
              stale_q <= 1'b1;
            end else if (operation_i == OP_LOAD_PROJ) begin
              proj_q[{row_index_i, 2'd0}] <= elem_0_i;
              proj_q[{row_index_i, 2'd1}] <= elem_1_i;
              proj_q[{row_index_i, 2'd2}] <= elem_2_i;
              proj_q[{row_index_i, 2'd3}] <= elem_3_i;
              stale_q <= 1'b1;
            end else if (operation_i == OP_TEST) begin
              cnt_q     <= '0;
              p_q       <= '0;
              outside_q <= 1'b0;
              state_q   <= stale_q ? S_MMUL : S_TEST;
            end
          end
        end
        S_MMUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_q <= S_MDRAIN;
        end
        S_MDRAIN: begin
          p_q     <= '0;
          state_q <= S_PADD;
        end
        S_PADD: begin
          for (int i = 0; i < 4; i++) pl_q[{p_q, i[1:0]}] <= pl_new[i];
          cnt_q   <= '0;
          state_q <= S_PSQ;
        end
        S_PSQ: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q[1:0] == 2'd2) state_q <= S_PSQD;
        end
        S_PSQD:  state_q <= S_SQRT;
        S_SQRT:  state_q <= S_SQRTW;
        S_SQRTW: begin
          if (ds_done) begin
            cnt_q <= '0;
            if (ds_res[WORD_BITS-1:0] == '0) begin
              if (p_q == 3'd5) begin
                stale_q <= 1'b0;
                p_q     <= '0;
                state_q <= S_TEST;
              end else begin
                p_q     <= p_q + 3'd1;
                state_q <= S_PADD;
              end
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (ds_done) begin
            pl_q[pl_idx] <= q_val;
            if (cnt_q[1:0] != 2'd3) begin
              cnt_q   <= cnt_q + 6'd1;
              state_q <= S_DIV;
            end else begin
              cnt_q <= '0;
              if (p_q == 3'd5) begin
                stale_q <= 1'b0;
                p_q     <= '0;
                state_q <= S_TEST;
              end else begin
                p_q     <= p_q + 3'd1;
                state_q <= S_PADD;
              end
            end
          end
        end
        S_TEST: begin
          if (cnt_q[1:0] == 2'd2) begin
            cnt_q <= '0;
            if (p_q == 3'd5) state_q <= S_TDRAIN;
            else p_q <= p_q + 3'd1;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_TDRAIN: state_q <= S_DONE;
        S_DONE:   state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
      if (pv_q && kind_q == KIND_TST && last_q &&
          $signed({dist_w[WORD_BITS-1], dist_w}) <= neg_r) begin
        outside_q <= 1'b1;
      end
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (accept && operation_i == OP_TEST) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      cz_q  <= center_z_i;
      r_q   <= radius_i;
      acc_q <= '0;
    end
    if (issue) begin
      kind_q <= kind_d;
      last_q <= last_d;
      tag_q  <= tag_d;
    end
    if (state_q == S_PADD) ss_q <= '0;
    if (state_q == S_SQRTW && ds_done) len_q <= ds_res[WORD_BITS-1:0];
    if (pv_q) begin
      unique case (kind_q)
        KIND_SQ: ss_q <= ss_q + prod;
        KIND_MAT: begin
          if (last_q) begin
            c_q[tag_q] <= sat_acc(sum);
            acc_q      <= '0;
          end else begin
            acc_q <= sum;
          end
        end
        default: begin
          acc_q <= last_q ? acc_t'(0) : sum;
        end
      endcase
    end
  end

  assign done_o       = (state_q == S_DONE);
  assign inside_res_o = !outside_q;

endmodule

// File: verif/testbench.sv
// Testbench of frustum_sphere_cull: directed table followed by random load/test
// sequences, results checked against a fixed-point frustum culling predictor or,
// for typed directed rows, the expected verdict in the table. Depends on fsc_pkg and the frustum_sphere_cull RTL.
`timescale 1ns / 1ps

module testbench;
  import fsc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int  CYCLE_LIMIT = 12000000;
  localparam int  MAX_GAP = 17;
  localparam longint ONE = 64'sd65536;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  row;
    word_t       elem[4];
    word_t       cx, cy, cz;
    logic [30:0] rad;
    bit          typed;
    bit          typed_inside;
  } cmd_t;

  logic clk_i, rst_ni, start, busy, done_o, inside_res_o;
  logic [1:0] operation_i, row_index_i;
  word_t elem_0_i, elem_1_i, elem_2_i, elem_3_i;
  word_t center_x_i, center_y_i, center_z_i;
  logic [WORD_BITS-2:0] radius_i;

  frustum_sphere_cull i_dut (.*);

  // Predictor state.
  longint view_m[16];
  longint proj_m[16];
  longint plane[24];
  bit     planes_stale;

  bit     inside_q[$];
  int     mismatches;
  int     cycles;
  int     sent;
  cmd_t   dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_product(longint a, longint b);
    logic        neg;
    logic [63:0] ma, mb, p, lim;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (p > lim) p = lim;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0]  r, cand;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  function automatic longint scale_coeff(longint num, logic [63:0] len);
    logic [63:0] n, q, lim;
    n = ((num < 0) ? -num : num) << FRAC_BITS;
    q = n / len;
    lim = (num < 0) ? 64'd2147483648 : 64'd2147483647;
    if (q > lim) q = lim;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic build_planes();
    longint       cm[16];
    longint       acc, base, other;
    logic [127:0] ss;
    logic [63:0]  mg, len;
    int           col;
    bit           add;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += fx_product(view_m[i*4+k], proj_m[k*4+j]);
        cm[i*4+j] = sat_word(acc);
      end
    // Planes in order right, left, bottom, top, back, front.
    for (int p = 0; p < 6; p++) begin
      col = p / 2;
      add = (p == 1) || (p == 2) || (p == 5);
      ss = '0;
      for (int i = 0; i < 4; i++) begin
        base = cm[i*4+3];
        other = cm[i*4+col];
        plane[p*4+i] = sat_word(add ? base + other : base - other);
        if (i < 3) begin
          mg = (plane[p*4+i] < 0) ? -plane[p*4+i] : plane[p*4+i];
          ss += {64'd0, mg} * {64'd0, mg};
        end
      end
      len = floor_sqrt(ss);
      if (len != 0)
        for (int i = 0; i < 4; i++) plane[p*4+i] = scale_coeff(plane[p*4+i], len);
    end
    planes_stale = 1'b0;
  endtask

  // Applies one accepted command; returns 1 with the verdict for sphere tests.
  task automatic predict_cull(input cmd_t c, output bit has_res, output bit is_in);
    longint dist_v, r;
    has_res = 1'b0;
    is_in = 1'b1;
    if (c.op == OP_LOAD_VIEW || c.op == OP_LOAD_PROJ) begin
      for (int j = 0; j < 4; j++)
        if (c.op == OP_LOAD_VIEW) view_m[c.row*4+j] = longint'(c.elem[j]);
        else proj_m[c.row*4+j] = longint'(c.elem[j]);
      planes_stale = 1'b1;
    end else if (c.op == OP_TEST) begin
      has_res = 1'b1;
      r = longint'(c.rad);
      if (planes_stale) build_planes();
      for (int p = 0; p < 6 && is_in; p++) begin
        dist_v = sat_word(fx_product(plane[p*4], longint'(c.cx)) +
                          fx_product(plane[p*4+1], longint'(c.cy)) +
                          fx_product(plane[p*4+2], longint'(c.cz)) + plane[p*4+3]);
        if (dist_v <= -r) is_in = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (inside_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result inside=%0b", inside_res_o);
      end else begin
        if (inside_res_o !== inside_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("inside mismatch: expected %0b, actual %0b", inside_q[0], inside_res_o);
        end
        void'(inside_q.pop_front());
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(cmd_t c, int gap);
    bit has_res, is_in;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i = c.op;
    row_index_i = c.row;
    elem_0_i = c.elem[0];
    elem_1_i = c.elem[1];
    elem_2_i = c.elem[2];
    elem_3_i = c.elem[3];
    center_x_i = c.cx;
    center_y_i = c.cy;
    center_z_i = c.cz;
    radius_i = c.rad;
    start = 1'b1;
    #1;
    while (busy) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    predict_cull(c, has_res, is_in);
    if (has_res) inside_q.push_back(c.typed ? c.typed_inside : is_in);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic cmd_t mk_cmd(logic [1:0] op, logic [1:0] row, word_t e0, word_t e1,
                                  word_t e2, word_t e3, word_t x, word_t y, word_t z,
                                  logic [30:0] r, bit typed, bit exp_inside);
    cmd_t c;
    c.op = op;
    c.row = row;
    c.elem[0] = e0; c.elem[1] = e1; c.elem[2] = e2; c.elem[3] = e3;
    c.cx = x; c.cy = y; c.cz = z;
    c.rad = r;
    c.typed = typed;
    c.typed_inside = exp_inside;
    return c;
  endfunction

  function automatic word_t rnd_word(bit full, int span);
    if (full) return word_t'($urandom);
    return word_t'(longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic cmd_t rnd_cmd(logic [1:0] op, bit full);
    cmd_t c;
    c.op = op;
    c.row = 2'($urandom_range(0, 3));
    for (int j = 0; j < 4; j++) c.elem[j] = rnd_word(full, 4 << 16);
    c.cx = rnd_word(full, 8 << 16);
    c.cy = rnd_word(full, 8 << 16);
    c.cz = rnd_word(full, 8 << 16);
    c.rad = full ? 31'($urandom) : 31'($urandom_range(0, 4 << 16));
    c.typed = 1'b0;
    c.typed_inside = 1'b0;
    return c;
  endfunction

  initial begin
    word_t wmax, wmin;
    cmd_t  c;
    int    n_load, n_test, gap_mode;
    bit    noise;

    wmax = 32'sh7FFFFFFF;
    wmin = 32'sh80000000;
    start = 1'b0;
    operation_i = OP_LOAD_VIEW;
    row_index_i = '0;
    {elem_0_i, elem_1_i, elem_2_i, elem_3_i} = '0;
    {center_x_i, center_y_i, center_z_i} = '0;
    radius_i = '0;
    mismatches = 0;
    cycles = 0;
    sent = 0;
    for (int i = 0; i < 16; i++) begin
      view_m[i] = (i % 5 == 0) ? ONE : 0;
      proj_m[i] = view_m[i];
    end
    planes_stale = 1'b1;

    // With identity matrices the frustum is the cube from -1 to 1.
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 32'sh30000, 0, 0, 0, 1, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 32'sh10000, 0, 0, 0, 1, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 32'sh20000, 0, 0, 31'h10001, 1, 1));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, wmax, wmax, wmax, 31'h7FFFFFFF, 0, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, wmin, wmin, wmin, 31'h7FFFFFFF, 0, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, wmin, wmax, 0, 0, 1, 0));
    dir_rows.push_back(mk_cmd(OP_UNUSED, 3, wmax, wmax, wmax, wmax, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    // A zero projection leaves every plane zero and unscaled.
    for (int r = 0; r < 4; r++)
      dir_rows.push_back(mk_cmd(OP_LOAD_PROJ, 2'(r), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 32'sh50000, 0, 0, 0, 1, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 32'sh50000, 0, 0, 1, 1, 1));
    // Saturating projection and view rows.
    dir_rows.push_back(mk_cmd(OP_LOAD_PROJ, 0, wmax, wmin, wmax, wmin, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_LOAD_PROJ, 3, wmin, wmax, wmin, wmax, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_LOAD_VIEW, 1, wmax, wmax, wmin, wmin, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_LOAD_VIEW, 2, wmin, wmin, wmax, wmax, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 32'sh10000, wmin, wmax, 31'h100, 0, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, wmax, 0, wmin, 31'h7FFFFFFF, 0, 0));
    dir_rows.push_back(mk_cmd(OP_LOAD_VIEW, 1, 0, word_t'(ONE), 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_LOAD_VIEW, 2, 0, 0, word_t'(ONE), 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_cmd(OP_TEST, 0, 0, 0, 0, 0, 32'sh8000, 32'shFFFF8000, 0, 0, 0, 0));

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_cmd(dir_rows[i], $urandom_range(0, MAX_GAP));

    while (sent < 1900) begin
      noise = ($urandom_range(0, 99) < 20);
      gap_mode = $urandom_range(0, 9);
      n_load = $urandom_range(0, 4);
      n_test = $urandom_range(2, 10);
      // Well-formed sequences load a few rows and then test several spheres.
      for (int i = 0; i < n_load + n_test; i++) begin
        if (noise)
          c = rnd_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 1) == 1);
        else if (i < n_load)
          c = rnd_cmd($urandom_range(0, 1) ? OP_LOAD_PROJ : OP_LOAD_VIEW,
                      $urandom_range(0, 19) == 0);
        else
          c = rnd_cmd(OP_TEST, $urandom_range(0, 9) == 0);
        send_cmd(c, (gap_mode < 3) ? 0 : $urandom_range(0, MAX_GAP));
      end
    end
    start = 1'b0;

    while (inside_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && inside_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
